[rtl/rmth_pkg.sv]
// Package with shared types and constants for the running median core.
package rmth_pkg;

  localparam int unsigned MEDIAN_W = 33;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned FIELD_W  = 32;

  // Heap operation codes issued by the controller.
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;

  // Command from the controller to one heap unit.
  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } heap_cmd_t;

  // Status from one heap unit back to the controller.
  typedef struct packed {
    logic busy;
  } heap_sts_t;

endpackage

[rtl/rmth_stream_if.sv]
// Valid/ready stream interface carrying a generic payload.
interface rmth_stream_if #(
  parameter int unsigned WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/rmth_heap.sv]
// One binary heap held in a memory with one write port and one registered read port, with a sequential sift engine.
module rmth_heap #(
  parameter int unsigned DEPTH  = 514,
  parameter int unsigned DATA_W = 32,
  parameter bit          IS_MAX = 1'b1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rmth_pkg::heap_cmd_t    cmd,
  input  logic [DATA_W-1:0]      push_value,
  output rmth_pkg::heap_sts_t    sts,
  output logic [DATA_W-1:0]      top_value,
  output logic [DATA_W-1:0]      pop_value,
  output logic [$clog2(DEPTH+1)-1:0] size
);
  import rmth_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = $clog2(DEPTH+1);

  // Engine states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UP_RD = 3'd1;
  localparam logic [2:0] S_UP_CK = 3'd2;
  localparam logic [2:0] S_DN_RL = 3'd3;
  localparam logic [2:0] S_DN_RR = 3'd4;
  localparam logic [2:0] S_DN_CK = 3'd5;
  localparam logic [2:0] S_PL_RD = 3'd6;
  localparam logic [2:0] S_PL_WR = 3'd7;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [2:0]        state_r, state_nxt;
  logic [SW-1:0]     size_r, size_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     cand_r, cand_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;       // value being sifted
  logic [DATA_W-1:0] best_r, best_nxt;     // best child value seen
  logic              has_best_r, has_best_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;       // cached root
  logic [DATA_W-1:0] pop_r, pop_nxt;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data_r;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic [AW:0]       left_w, right_w;
  logic [AW-1:0]     parent_w;

  // True if a should sit above b in this heap.
  function automatic logic above(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    if (IS_MAX) begin
      above = $signed(a) > $signed(b);
    end else begin
      above = $signed(a) < $signed(b);
    end
  endfunction

  assign parent_w = AW'((idx_r - 1'b1) >> 1);
  assign left_w   = {idx_r, 1'b1};
  assign right_w  = left_w + 1'b1;

  // Memory with registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sift sequencer.
  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    idx_nxt      = idx_r;
    cand_nxt     = cand_r;
    val_nxt      = val_r;
    best_nxt     = best_r;
    has_best_nxt = has_best_r;
    top_nxt      = top_r;
    pop_nxt      = pop_r;
    rd_en        = 1'b0;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = idx_r;
    wr_data      = val_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start && cmd.op == OP_PUSH) begin
          idx_nxt  = AW'(size_r);
          val_nxt  = push_value;
          size_nxt = size_r + 1'b1;
          if (size_r == '0) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = push_value;
            top_nxt = push_value;
          end else begin
            state_nxt = S_UP_RD;
          end
        end else if (cmd.start && cmd.op == OP_POP) begin
          pop_nxt  = top_r;
          size_nxt = size_r - 1'b1;
          idx_nxt  = '0;
          if (size_r > SW'(1)) begin
            rd_en     = 1'b1;
            rd_addr   = AW'(size_r - 1'b1);
            state_nxt = S_PL_RD;
          end
        end
      end
      // Read parent of the hole.
      S_UP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = parent_w;
        state_nxt = S_UP_CK;
      end
      S_UP_CK: begin
        if (above(val_r, rd_data_r)) begin
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = rd_data_r;
          idx_nxt = parent_w;
          if (parent_w == '0) begin
            wr_en     = 1'b1;
            state_nxt = S_PL_WR;
            idx_nxt   = '0;
          end else begin
            state_nxt = S_UP_RD;
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = idx_r;
          wr_data   = val_r;
          state_nxt = S_IDLE;
        end
      end
      // Last element fetched: it becomes the value sifted down from the root.
      S_PL_RD: begin
        val_nxt   = rd_data_r;
        state_nxt = S_DN_RL;
      end
      S_DN_RL: begin
        has_best_nxt = 1'b0;
        if ({1'b0, left_w} < {1'b0, size_r}) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(left_w);
          state_nxt = S_DN_RR;
        end else begin
          state_nxt = S_PL_WR;
        end
      end
      S_DN_RR: begin
        best_nxt     = rd_data_r;
        cand_nxt     = AW'(left_w);
        has_best_nxt = above(rd_data_r, val_r);
        if ({1'b0, right_w} < {1'b0, size_r}) begin
          rd_en   = 1'b1;
          rd_addr = AW'(right_w);
        end
        state_nxt = S_DN_CK;
      end
      S_DN_CK: begin
        if ({1'b0, right_w} < {1'b0, size_r} && above(rd_data_r, val_r)
            && (!has_best_r || above(rd_data_r, best_r))) begin
          wr_en   = 1'b1;
          wr_data = rd_data_r;
          if (idx_r == '0) top_nxt = rd_data_r;
          idx_nxt   = AW'(right_w);
          state_nxt = S_DN_RL;
        end else if (has_best_r) begin
          wr_en   = 1'b1;
          wr_data = best_r;
          if (idx_r == '0) top_nxt = best_r;
          idx_nxt   = cand_r;
          state_nxt = S_DN_RL;
        end else begin
          state_nxt = S_PL_WR;
        end
      end
      // Final placement of the sifted value.
      S_PL_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = val_r;
        if (idx_r == '0) top_nxt = val_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
    end
    idx_r      <= idx_nxt;
    cand_r     <= cand_nxt;
    val_r      <= val_nxt;
    best_r     <= best_nxt;
    has_best_r <= has_best_nxt;
    top_r      <= top_nxt;
    pop_r      <= pop_nxt;
  end

  assign sts.busy  = (state_r != S_IDLE);
  assign top_value = top_r;
  assign pop_value = pop_r;
  assign size      = size_r;

  // The heap never grows beyond its storage.
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SW'(DEPTH)) else $error("heap size beyond depth");
  // A command is only issued while the engine is idle.
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> state_r == S_IDLE) else $error("command while busy");
  // A push always grows the heap by one.
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && cmd.op == OP_PUSH) |=> size_r == $past(size_r) + 1'b1)
    else $error("push did not grow heap");

endmodule

[rtl/rmth_ctrl.sv]
// Controller sequencing insert, rebalance and result for each transaction, or only the result when the store is full.
module rmth_ctrl #(
  parameter int unsigned SW = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                full,
  input  logic                go_lower,
  input  logic [SW-1:0]       lower_size,
  input  logic [SW-1:0]       upper_size,
  input  rmth_pkg::heap_sts_t lower_sts,
  input  rmth_pkg::heap_sts_t upper_sts,
  input  logic                out_ready,
  output rmth_pkg::heap_cmd_t lower_cmd,
  output rmth_pkg::heap_cmd_t upper_cmd,
  output logic                sel_move_from_lower,
  output logic                in_ready,
  output logic                out_valid,
  output logic                count_inc
);
  import rmth_pkg::*;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_INS  = 3'd1;
  localparam logic [2:0] C_BAL  = 3'd2;
  localparam logic [2:0] C_POP  = 3'd3;
  localparam logic [2:0] C_PUSH = 3'd4;
  localparam logic [2:0] C_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       from_lower_r, from_lower_nxt;
  logic       heaps_busy;

  assign heaps_busy = lower_sts.busy || upper_sts.busy;

  always_comb begin
    state_nxt      = state_r;
    from_lower_nxt = from_lower_r;
    lower_cmd      = '{start: 1'b0, op: OP_PUSH};
    upper_cmd      = '{start: 1'b0, op: OP_PUSH};
    count_inc      = 1'b0;
    case (state_r)
      C_IDLE: begin
        if (in_fire) begin
          if (full) begin
            state_nxt = C_OUT;
          end else begin
            count_inc = 1'b1;
            if (go_lower) lower_cmd.start = 1'b1;
            else          upper_cmd.start = 1'b1;
            state_nxt = C_INS;
          end
        end
      end
      C_INS: if (!heaps_busy) state_nxt = C_BAL;
      C_BAL: begin
        if (lower_size > upper_size + 1'b1) begin
          from_lower_nxt  = 1'b1;
          lower_cmd       = '{start: 1'b1, op: OP_POP};
          state_nxt       = C_POP;
        end else if (upper_size > lower_size) begin
          from_lower_nxt  = 1'b0;
          upper_cmd       = '{start: 1'b1, op: OP_POP};
          state_nxt       = C_POP;
        end else begin
          state_nxt = C_OUT;
        end
      end
      C_POP: begin
        if (!heaps_busy) begin
          if (from_lower_r) upper_cmd.start = 1'b1;
          else              lower_cmd.start = 1'b1;
          state_nxt = C_PUSH;
        end
      end
      C_PUSH: if (!heaps_busy) state_nxt = C_OUT;
      C_OUT:  if (out_ready) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= C_IDLE;
      from_lower_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      from_lower_r <= from_lower_nxt;
    end
  end

  assign sel_move_from_lower = from_lower_r;
  assign in_ready  = (state_r == C_IDLE);
  assign out_valid = (state_r == C_OUT);

  // Input and output are never offered together.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in and out both open");
  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  // Heaps never both work at once.
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(lower_sts.busy && upper_sts.busy)) else $error("both heaps busy");

endmodule

[rtl/running_median_two_heaps_core.sv]
// Top level of the running median core built from two heaps.
//  channel | direction | payload
//  in      | sink      | sample_value
//  out     | source    | median_doubled, stored_count, store_full
// One transaction is in work at a time. A push climbs a level by reading and comparing the
// parent, and a pop sinks a level by reading the left child, reading the right child and
// comparing. A full store offers its result in the cycle after acceptance. Reset empties
// both heaps.
// A stalled result holds the block; no new sample is taken until it leaves.
module running_median_two_heaps_core #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  rmth_stream_if.sink   in_if,
  rmth_stream_if.source out_if
);
  import rmth_pkg::*;

  localparam int unsigned DEPTH = CAPACITY / 2 + 2;
  localparam int unsigned SW    = $clog2(DEPTH + 1);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);

  heap_cmd_t lower_cmd, upper_cmd, lcmd, ucmd;
  heap_sts_t lower_sts, upper_sts;
  logic [SAMPLE_BITS-1:0] lower_top, upper_top, lower_pop, upper_pop;
  logic [SAMPLE_BITS-1:0] lpush, upush;
  logic [SW-1:0] lower_size, upper_size;
  logic [CW-1:0] count_r;
  logic          full_r, from_lower, in_fire, count_inc, go_lower, is_full;
  logic [SAMPLE_BITS-1:0] samp;
  logic signed [SAMPLE_BITS:0] med;

  assign samp    = in_if.data[SAMPLE_BITS-1:0];
  assign in_fire = in_if.valid && in_if.ready;
  assign is_full = (count_r >= CW'(CAPACITY));
  assign go_lower = (lower_size == '0) || ($signed(samp) <= $signed(lower_top));

  // Sample count and full flag for the transaction in work.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (count_inc) begin
      count_r <= count_r + 1'b1;
    end
    if (in_fire) begin
      full_r   <= is_full;
    end
  end

  // Pushes take the sample directly, or the popped value during a move.
  assign lpush = (!in_if.ready && !from_lower) ? upper_pop : samp;
  assign upush = (!in_if.ready && from_lower) ? lower_pop : samp;
  assign lcmd  = lower_cmd;
  assign ucmd  = upper_cmd;

  rmth_ctrl #(.SW(SW)) u_ctrl (
    .clk, .rst_n, .in_fire, .full(is_full), .go_lower,
    .lower_size, .upper_size, .lower_sts, .upper_sts,
    .out_ready(out_if.ready), .lower_cmd, .upper_cmd,
    .sel_move_from_lower(from_lower), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .count_inc
  );

  rmth_heap #(.DEPTH(DEPTH), .DATA_W(SAMPLE_BITS), .IS_MAX(1'b1)) u_lower (
    .clk, .rst_n, .cmd(lcmd), .push_value(lpush), .sts(lower_sts),
    .top_value(lower_top), .pop_value(lower_pop), .size(lower_size)
  );

  rmth_heap #(.DEPTH(DEPTH), .DATA_W(SAMPLE_BITS), .IS_MAX(1'b0)) u_upper (
    .clk, .rst_n, .cmd(ucmd), .push_value(upush), .sts(upper_sts),
    .top_value(upper_top), .pop_value(upper_pop), .size(upper_size)
  );

  // Twice the median from the two tops.
  always_comb begin
    if (lower_size == '0) begin
      med = '0;
    end else if (lower_size > upper_size || upper_size == '0) begin
      med = {lower_top, 1'b0};
    end else begin
      med = $signed({lower_top[SAMPLE_BITS-1], lower_top})
          + $signed({upper_top[SAMPLE_BITS-1], upper_top});
    end
  end

  assign out_if.data = {MEDIAN_W'(med), COUNT_W'(count_r), full_r};

  // A result reports the count only after the insert it belongs to.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> count_r == CW'(lower_size) + CW'(upper_size))
    else $error("count out of step with heaps");
  // Lower heap holds the same or one more entry once balanced.
  a_bal: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (lower_size == upper_size || lower_size == upper_size + 1'b1))
    else $error("heaps unbalanced");
  // A rejected sample leaves the count unchanged.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_full) |=> $stable(count_r)) else $error("count moved when full");

endmodule
